// ===== rtl/lpa_pkg.sv =====
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared types, field widths and default parameter values for the LIFO page
// allocator.
// ----------------------------------------------------------------------------
package lpa_pkg;

    // Default values for the top-level parameters.
    localparam int DEFAULT_PAGE_BYTES   = 4096;
    localparam int DEFAULT_STACK_DEPTH  = 64;
    localparam int DEFAULT_ADDRESS_BITS = 48;

    // Fixed field widths of the request and response.
    localparam int ADDR_W       = 48;
    localparam int COUNT_W      = 32;
    localparam int ESIZE_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 36;
    localparam int PAGE_CNT_W   = 24;
    localparam int BYTES_W      = COUNT_W + ESIZE_W;
    localparam int PAGES_WIDE_W = 40;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_ORDER = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

endpackage

// ===== rtl/lpa_ram.sv =====
// ----------------------------------------------------------------------------
// lpa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lifo_page_allocator.sv =====
// ----------------------------------------------------------------------------
// lifo_page_allocator
// Stack-ordered page allocator over one contiguous region starting at a
// configurable base address.
//
// Each request goes through a transfer cycle, in which the current top entry
// is read from the stack memory, and an update cycle, in which the
// memory's read data is checked, the new entry is written back and the
// response register is loaded. The block takes one request at a time, and a
// new request is accepted as soon as the update is done, even while the
// previous response still waits in the output register; the update cycle
// waits only while that register is still occupied. Entries and page counts
// live together in one memory of STACK_DEPTH words, which needs no clearing
// after reset since only live entries are ever used. PAGE_BYTES must be a
// power of two.
// ----------------------------------------------------------------------------
module lifo_page_allocator #(
    parameter int PAGE_BYTES   = lpa_pkg::DEFAULT_PAGE_BYTES,
    parameter int STACK_DEPTH  = lpa_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDRESS_BITS = lpa_pkg::DEFAULT_ADDRESS_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [lpa_pkg::ADDR_W-1:0]    cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [lpa_pkg::COUNT_W-1:0]   element_count,
    input  logic [lpa_pkg::ESIZE_W-1:0]   element_size,
    input  logic [lpa_pkg::ADDR_W-1:0]    free_address,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpa_pkg::ADDR_W-1:0]    address,
    output lpa_pkg::status_t              status,
    output logic [lpa_pkg::TOTAL_W-1:0]   pages_in_use
);

    import lpa_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W    = ADDRESS_BITS + PAGE_CNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [CNT_W-1:0]        entry_count_reg, entry_count_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic                    op_reg, op_next;
    logic [BYTES_W-1:0]      bytes_reg, bytes_next;
    logic [ADDR_W-1:0]       free_addr_reg, free_addr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]       address_reg, address_next;
    status_t                 status_reg, status_next;
    logic [TOTAL_W-1:0]      pages_in_use_reg, pages_in_use_next;

    logic                    accept;
    logic                    commit;
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [ENTRY_W-1:0]      ram_wr_data;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [ENTRY_W-1:0]      ram_rd_data;

    logic [ADDRESS_BITS-1:0] top_end;
    logic [PAGE_CNT_W-1:0]   top_pages;
    logic [ADDRESS_BITS-1:0] top_addr;
    logic                    stack_empty;
    logic                    stack_full;
    logic [PAGES_WIDE_W-1:0] pages_wide;
    logic [PAGE_CNT_W-1:0]   req_pages;
    logic                    too_big;
    logic [ADDRESS_BITS-1:0] alloc_end;
    logic [ADDRESS_BITS-1:0] free_end;

    lpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign commit       = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign address      = address_reg;
    assign status       = status_reg;
    assign pages_in_use = pages_in_use_reg;

    // The top entry sits one below the fill count. On an empty stack the read
    // returns stale data, which the update cycle ignores.
    assign ram_rd_addr = IDX_W'(entry_count_reg - CNT_W'(1));

    assign top_end     = ram_rd_data[ENTRY_W-1:PAGE_CNT_W];
    assign top_pages   = ram_rd_data[PAGE_CNT_W-1:0];
    assign stack_empty = (entry_count_reg == '0);
    assign stack_full  = (entry_count_reg >= CNT_W'(STACK_DEPTH));
    assign top_addr    = stack_empty ? ADDRESS_BITS'(base_reg) : top_end;

    // Round the byte count up to whole pages.
    assign pages_wide = PAGES_WIDE_W'(bytes_reg >> PAGE_SHIFT)
                      + PAGES_WIDE_W'(|bytes_reg[PAGE_SHIFT-1:0]);
    assign req_pages  = pages_wide[PAGE_CNT_W-1:0];
    assign too_big    = |pages_wide[PAGES_WIDE_W-1:PAGE_CNT_W];

    assign alloc_end = top_addr
                     + ADDRESS_BITS'({req_pages, {PAGE_SHIFT{1'b0}}});
    assign free_end  = ADDRESS_BITS'(free_addr_reg)
                     + ADDRESS_BITS'({top_pages, {PAGE_SHIFT{1'b0}}});

    assign ram_wr_addr = entry_count_reg[IDX_W-1:0];
    assign ram_wr_data = {alloc_end, req_pages};

    always_comb
    begin
        state_next        = state_reg;
        base_next         = base_reg;
        entry_count_next  = entry_count_reg;
        total_next        = total_reg;
        op_next           = op_reg;
        bytes_next        = bytes_reg;
        free_addr_next    = free_addr_reg;
        out_valid_next    = out_valid_reg;
        address_next      = address_reg;
        status_next       = status_reg;
        pages_in_use_next = pages_in_use_reg;
        ram_wr_en         = 1'b0;

        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = operation;
                    bytes_next     = BYTES_W'(element_count) * BYTES_W'(element_size);
                    free_addr_next = free_address;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    address_next = '0;
                    status_next  = STATUS_OK;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (stack_full || too_big)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_wr_en        = 1'b1;
                            entry_count_next = entry_count_reg + CNT_W'(1);
                            total_next       = total_reg + TOTAL_W'(req_pages);
                            address_next     = ADDR_W'(top_addr);
                        end
                    end
                    else if (stack_empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else if (free_end != top_end)
                    begin
                        status_next = STATUS_ORDER;
                    end
                    else
                    begin
                        entry_count_next = entry_count_reg - CNT_W'(1);
                        total_next       = total_reg - TOTAL_W'(top_pages);
                    end
                    pages_in_use_next = total_next;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            base_reg         <= '0;
            entry_count_reg  <= '0;
            total_reg        <= '0;
            op_reg           <= OP_ALLOC;
            bytes_reg        <= '0;
            free_addr_reg    <= '0;
            out_valid_reg    <= 1'b0;
            address_reg      <= '0;
            status_reg       <= STATUS_OK;
            pages_in_use_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            base_reg         <= base_next;
            entry_count_reg  <= entry_count_next;
            total_reg        <= total_next;
            op_reg           <= op_next;
            bytes_reg        <= bytes_next;
            free_addr_reg    <= free_addr_next;
            out_valid_reg    <= out_valid_next;
            address_reg      <= address_next;
            status_reg       <= status_next;
            pages_in_use_reg <= pages_in_use_next;
        end
    end

    // The fill count never exceeds the memory depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(STACK_DEPTH))
    else $error("stack fill count beyond depth");

    // Every accepted request goes straight to the update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
    else $error("accepted request did not reach the update cycle");

    // A rejected request leaves the stack and the page total untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && status_next != STATUS_OK
        |=> $stable(entry_count_reg) && $stable(total_reg))
    else $error("rejected request changed allocator state");

    // A successful free pops exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && op_reg == OP_FREE && status_next == STATUS_OK
        |=> entry_count_reg == $past(entry_count_reg) - CNT_W'(1))
    else $error("successful free did not pop one entry");

    // Memory writes happen only in the update cycle of an allocation.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> commit && op_reg == OP_ALLOC && !stack_full)
    else $error("stack memory written outside an allocation");

endmodule

// ===== verif/lpa_checker.sv =====
// ----------------------------------------------------------------------------
// lpa_checker
// Watches the configuration port and both channels of the LIFO page allocator.
// It keeps its own copy of the allocation stack and the page total. It works
// out the response to every accepted request and compares each response
// transfer, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module lpa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lpa_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          operation,
    input  logic [lpa_pkg::COUNT_W-1:0]   element_count,
    input  logic [lpa_pkg::ESIZE_W-1:0]   element_size,
    input  logic [lpa_pkg::ADDR_W-1:0]    free_address,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lpa_pkg::ADDR_W-1:0]    address,
    input  lpa_pkg::status_t              status,
    input  logic [lpa_pkg::TOTAL_W-1:0]   pages_in_use,
    output int                            pending,
    output int                            live_depth,
    output logic [lpa_pkg::ADDR_W-1:0]    top_start,
    output int                            error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpa_pkg::*;

    localparam int         STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam logic [63:0] PAGE_SIZE  = 64'(DEFAULT_PAGE_BYTES);
    localparam logic [63:0] PAGE_LIMIT = (64'd1 << PAGE_CNT_W) - 64'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        status_t            status;
        logic [TOTAL_W-1:0] pages_in_use;
    } alloc_reply_t;

    alloc_reply_t          reply_queue [$];
    logic [ADDR_W-1:0]     end_addr [STACK_DEPTH];
    logic [PAGE_CNT_W-1:0] page_cnt [STACK_DEPTH];
    int                    live;
    logic [TOTAL_W-1:0]    page_total;
    logic [ADDR_W-1:0]     region_base;

    // Applies one request to the shadow stack and returns the response.
    function automatic alloc_reply_t apply_request(input op_t op,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic [ESIZE_W-1:0] esize,
                                                   input logic [ADDR_W-1:0] faddr);
        logic [63:0]       bytes;
        logic [63:0]       pages;
        logic [ADDR_W-1:0] top;
        alloc_reply_t      reply;
        reply.address = '0;
        reply.status  = STATUS_OK;
        if (op == OP_ALLOC)
        begin
            bytes = 64'(count) * 64'(esize);
            pages = (bytes + PAGE_SIZE - 64'd1) / PAGE_SIZE;
            if (live >= STACK_DEPTH || pages > PAGE_LIMIT)
            begin
                reply.status = STATUS_FULL;
            end
            else
            begin
                top = (live == 0) ? region_base : end_addr[live-1];
                end_addr[live] = top + ADDR_W'(pages * PAGE_SIZE);
                page_cnt[live] = PAGE_CNT_W'(pages);
                live++;
                page_total = page_total + TOTAL_W'(pages);
                reply.address = top;
            end
        end
        else if (live == 0)
        begin
            reply.status = STATUS_EMPTY;
        end
        else if (faddr + ADDR_W'(64'(page_cnt[live-1]) * PAGE_SIZE) != end_addr[live-1])
        begin
            reply.status = STATUS_ORDER;
        end
        else
        begin
            live--;
            page_total = page_total - TOTAL_W'(page_cnt[live]);
        end
        reply.pages_in_use = page_total;
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        alloc_reply_t got;
        alloc_reply_t want;
        if (!rst_n)
        begin
            live        = 0;
            page_total  = '0;
            region_base = '0;
            error_count = 0;
            reply_queue.delete();
        end
        else
        begin
            // Check the response first so that a request accepted on the same
            // edge never lines up against it.
            if (out_valid && out_ready)
            begin
                got.address      = address;
                got.status       = status;
                got.pages_in_use = pages_in_use;
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: response transfer with none outstanding, actual %h %0d %h",
                             $time, got.address, got.status, got.pages_in_use);
                    error_count++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (got.address !== want.address)
                    begin
                        $display("%0t: address mismatch, expected %h, actual %h",
                                 $time, want.address, got.address);
                        error_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.pages_in_use !== want.pages_in_use)
                    begin
                        $display("%0t: pages_in_use mismatch, expected %h, actual %h",
                                 $time, want.pages_in_use, got.pages_in_use);
                        error_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                region_base = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                reply_queue.push_back(apply_request(op_t'(operation), element_count,
                                                    element_size, free_address));
            end
        end
        // Registered copies for the stimulus side, so it never races this block.
        pending    <= reply_queue.size();
        live_depth <= live;
        if (live == 0)
        begin
            top_start <= region_base;
        end
        else
        begin
            top_start <= end_addr[live-1] - ADDR_W'(64'(page_cnt[live-1]) * PAGE_SIZE);
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the LIFO page allocator. It runs a short directed sequence
// over the empty, oversized, zero-size, wrapping and out-of-order cases. It
// then runs random phases under several region bases. Those phases mostly
// fill and drain the stack with well-formed requests, mixed with random
// requests and bad frees. Both channels idle in random bursts, except in the
// last phase. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpa_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 325;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [ADDR_W-1:0]   cfg_wr_data   = '0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic                operation     = 1'b0;
    logic [COUNT_W-1:0]  element_count = '0;
    logic [ESIZE_W-1:0]  element_size  = '0;
    logic [ADDR_W-1:0]   free_address  = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [ADDR_W-1:0]   address;
    status_t             status;
    logic [TOTAL_W-1:0]  pages_in_use;

    int                  pending;
    int                  live_depth;
    logic [ADDR_W-1:0]   top_start;
    int                  error_count;
    int                  cycle_count = 0;
    bit                  quiet       = 1'b0;
    bit                  filling     = 1'b1;

    lifo_page_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .element_count (element_count),
        .element_size  (element_size),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .address       (address),
        .status        (status),
        .pages_in_use  (pages_in_use)
    );

    lpa_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .element_count (element_count),
        .element_size  (element_size),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .address       (address),
        .status        (status),
        .pages_in_use  (pages_in_use),
        .pending       (pending),
        .live_depth    (live_depth),
        .top_start     (top_start),
        .error_count   (error_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), $urandom};
    endfunction

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Presents one request and returns on the edge of its transfer.
    task automatic send_request(input op_t op, input logic [COUNT_W-1:0] count,
                                input logic [ESIZE_W-1:0] esize,
                                input logic [ADDR_W-1:0] faddr);
        in_valid      <= 1'b1;
        operation     <= op;
        element_count <= count;
        element_size  <= esize;
        free_address  <= faddr;
        do @(posedge clk); while (!in_ready);
    endtask

    // Idling the input lets the checker's view of the stack top catch up with
    // the request that was just transferred.
    task automatic free_top();
        idle_input(1);
        send_request(OP_FREE, $urandom, 5'($urandom), top_start);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request();
        logic [COUNT_W-1:0] count;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            idle_input($urandom_range(1, 14));
        end
        // Walk the stack between empty and full, with an occasional turn.
        if (filling && live_depth >= STACK_DEPTH && $urandom_range(0, 3) == 0)
        begin
            filling = 1'b0;
        end
        else if (!filling && live_depth == 0 && $urandom_range(0, 3) == 0)
        begin
            filling = 1'b1;
        end
        else if ($urandom_range(0, 59) == 0)
        begin
            filling = !filling;
        end
        if (pick < 80)
        begin
            if (filling)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: count = $urandom_range(0, 3000);
                    6, 7:             count = $urandom_range(0, 1 << 20);
                    default:          count = $urandom;
                endcase
                send_request(OP_ALLOC, count, 5'($urandom), rand_addr());
            end
            else
            begin
                free_top();
            end
        end
        else if (pick < 90)
        begin
            send_request(OP_ALLOC, $urandom, 5'($urandom), rand_addr());
        end
        else if (pick < 95)
        begin
            idle_input(1);
            send_request(OP_FREE, $urandom, 5'($urandom),
                         top_start ^ (48'd1 << $urandom_range(0, ADDR_W - 1)));
        end
        else
        begin
            send_request(OP_FREE, $urandom, 5'($urandom), rand_addr());
        end
    endtask

    // Result side: random stall bursts, none once the run goes quiet.
    initial
    begin : result_stalls
        forever
        begin
            @(posedge clk);
            if (!quiet && rst_n && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] region_base;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base('0);
        send_request(OP_FREE, 32'd0, 5'd0, '0);
        send_request(OP_FREE, 32'hFFFF_FFFF, 5'd31, '1);
        send_request(OP_ALLOC, 32'd0, 5'd7, '0);
        free_top();
        send_request(OP_ALLOC, 32'd1, 5'd1, '0);
        send_request(OP_ALLOC, 32'd4096, 5'd1, '1);
        send_request(OP_ALLOC, 32'd4097, 5'd1, '0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd16, '0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd31, '0);
        // The largest page count that still fits an entry.
        send_request(OP_ALLOC, 32'hFFFF_FF00, 5'd16, '0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd0, '0);
        idle_input(1);
        send_request(OP_FREE, 32'd0, 5'd0, top_start + 48'h1000);
        send_request(OP_FREE, 32'd0, 5'd0, '1);
        repeat (5) free_top();
        send_request(OP_FREE, 32'd0, 5'd0, '0);

        // Allocations at the top of the address space wrap around to zero.
        write_base(48'hFFFF_FFFF_F000);
        send_request(OP_ALLOC, 32'd8192, 5'd1, '0);
        send_request(OP_ALLOC, 32'd1, 5'd16, '0);
        free_top();
        free_top();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       region_base = 48'hFFFF_FFFF_F000;
                1:       region_base = rand_addr() & ~48'hFFF;
                2:       region_base = '0;
                3:       region_base = rand_addr();
                4:       region_base = 48'h8000_0000_0000;
                default: region_base = 48'hFFFF_FFF0_0000;
            endcase
            write_base(region_base);
            if (phase == 5)
            begin
                quiet = 1'b1;
            end
            repeat (PHASE_ITEMS) random_request();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
